// File: rtl/lssq_pkg.sv
// Shared types and constants for the layered stable sorted queue.
// No dependencies.
package lssq_pkg;

    typedef struct packed {
        logic [2:0]         layer;
        logic signed [15:0] key;
        logic [15:0]        handle;
    } entry_t;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_EMITTED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

endpackage

// File: rtl/layered_stable_sorted_queue_top.sv
// Layered stable sorted queue: top level with sequencer and output register.
// Depends on lssq_pkg, lssq_store, lssq_cmp.
//
// The block holds up to CAPACITY entries sorted by layer, then by signed key, with equal
// entries in arrival order. An insert walks the table from its tail, moving each entry that
// sorts after the new one up by one slot, and ends with its one status transfer. A drain
// returns every entry in order, with last set on the final one; an empty table gives one
// empty-status transfer. The table memory is read at one address per cycle with registered
// read data, and there is one compare unit. s_ready is high only while the sequencer is
// idle. The table needs no clearing after reset.
module layered_stable_sorted_queue_top #(
    parameter int CAPACITY    = 32,
    parameter int LAYER_COUNT = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [2:0]  s_layer,
    input  logic signed [15:0] s_order_key,
    input  logic [15:0] s_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_out_handle,
    output logic [2:0]  m_out_layer,
    output logic signed [15:0] m_out_key,
    output logic        m_last
);
    import lssq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_PLACE,
        S_RESP,
        S_DRD,
        S_DOUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    entry_t        new_reg, new_next;
    logic [1:0]    resp_reg, resp_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   handle_reg, handle_next;
    logic [2:0]    layer_reg, layer_next;
    logic signed [15:0] key_reg, key_next;
    logic          last_reg, last_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          goes_after;
    logic          out_free;
    logic [2:0]    sat_layer;
    logic          drain_last;

    lssq_store #(.DEPTH(CAPACITY)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lssq_cmp u_cmp (
        .stored     (rd_data),
        .incoming   (new_reg),
        .goes_after (goes_after)
    );

    always_comb begin
        if (32'(s_layer) > LAYER_COUNT - 1) begin
            sat_layer = 3'(LAYER_COUNT - 1);
        end else begin
            sat_layer = s_layer;
        end
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign rd_addr    = (state_reg == S_READ) ? idx_reg - AW'(1) : idx_reg;
    assign drain_last = CW'(idx_reg) == count_reg - CW'(1);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        new_next     = new_reg;
        resp_next    = resp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        handle_next  = handle_reg;
        layer_next   = layer_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = new_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    new_next.layer  = sat_layer;
                    new_next.key    = s_order_key;
                    new_next.handle = s_handle;
                    idx_next        = '0;
                    if (s_func == FUNC_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            resp_next  = ST_DROPPED;
                            state_next = S_RESP;
                        end else begin
                            idx_next   = count_reg[AW-1:0];
                            state_next = (count_reg == '0) ? S_PLACE : S_READ;
                        end
                    end else if (count_reg == '0) begin
                        resp_next  = ST_EMPTY;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_DRD;
                    end
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (goes_after) begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = idx_reg - AW'(1);
                    state_next = (idx_reg == AW'(1)) ? S_PLACE : S_READ;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                resp_next  = ST_INSERTED;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    status_next  = resp_reg;
                    handle_next  = '0;
                    layer_next   = '0;
                    key_next     = '0;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DRD: begin
                state_next = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_EMITTED;
                    handle_next  = rd_data.handle;
                    layer_next   = rd_data.layer;
                    key_next     = rd_data.key;
                    last_next    = drain_last;
                    if (drain_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_DRD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        new_reg    <= new_next;
        resp_reg   <= resp_next;
        status_reg <= status_next;
        handle_reg <= handle_next;
        layer_reg  <= layer_next;
        key_reg    <= key_next;
        last_reg   <= last_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_out_handle = handle_reg;
    assign m_out_layer  = layer_reg;
    assign m_out_key    = key_reg;
    assign m_last       = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_CMP || state_reg == S_PLACE))
        else $error("table write outside insert");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_out_handle == '0 && m_last))
        else $error("empty status with entry data or without last");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the table");

endmodule

// File: rtl/lssq_store.sv
// Entry table: one write port, one read port with registered read data.
// Depends on lssq_pkg.
module lssq_store #(
    parameter int DEPTH = 32
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  lssq_pkg::entry_t           wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output lssq_pkg::entry_t           rd_data
);
    import lssq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lssq_cmp.sv
// Order compare: stored entry sorts after the new one (higher layer, or same layer
// and strictly greater key). Depends on lssq_pkg.
module lssq_cmp (
    input  lssq_pkg::entry_t stored,
    input  lssq_pkg::entry_t incoming,
    output logic             goes_after
);
    import lssq_pkg::*;

    logic layer_gt;
    logic layer_eq;
    logic key_gt;

    always_comb begin
        layer_gt   = stored.layer > incoming.layer;
        layer_eq   = stored.layer == incoming.layer;
        key_gt     = $signed(stored.key) > $signed(incoming.key);
        goes_after = layer_gt || (layer_eq && key_gt);
    end

endmodule
